@@ hdl/asb_pkg.sv @@
package asb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POS_X         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ANCHOR = 3'd6;

    localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // width of the position arithmetic, two's complement
    localparam int POS_W = 16;

    typedef struct packed {
        logic [7:0] src_c0;
        logic [7:0] src_c1;
        logic [7:0] src_c2;
        logic [7:0] src_alpha;
        logic [7:0] dst_c0;
        logic [7:0] dst_c1;
        logic [7:0] dst_c2;
    } t_in_req;

    typedef struct packed {
        logic        write_enable;
        logic [23:0] pixel_address;
        logic [7:0]  out_c0;
        logic [7:0]  out_c1;
        logic [7:0]  out_c2;
        logic        last_pixel;
    } t_out_req;

    typedef struct packed {
        logic [12:0] dest_width;
        logic [12:0] dest_height;
        logic [10:0] sprite_width;
        logic [10:0] sprite_height;
        logic [13:0] pos_x;
        logic [13:0] pos_y;
        logic        center_anchor;
    } t_cfg;

    typedef struct packed {
        logic write_enable;
        logic last_pixel;
    } t_pix_ctl;

    // dst + floor(alpha * (src - dst) / 256), kept modulo 256
    function automatic logic [7:0] blend(input logic [7:0] src, input logic [7:0] dst,
                                         input logic [7:0] alpha);
        logic signed [8:0]  diff;
        logic signed [17:0] prod;
        logic signed [17:0] shifted;
        diff    = $signed({1'b0, src}) - $signed({1'b0, dst});
        prod    = diff * $signed({1'b0, alpha});
        shifted = prod >>> 8;
        return dst + shifted[7:0];
    endfunction

endpackage

@@ hdl/asb_pos.sv @@
module asb_pos #(
    parameter int MAX_DEST_DIM   = 4096,
    parameter int MAX_SPRITE_DIM = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  asb_pkg::t_cfg                     i_cfg,
    input  logic [$clog2(MAX_DEST_DIM+1)-1:0] i_dw,
    input  logic [$clog2(MAX_DEST_DIM+1)-1:0] i_dh,
    input  logic                              i_in_valid,
    input  logic                              i_ready,
    input  asb_pkg::t_in_req                  i_in_data,
    output logic                              o_valid,
    output asb_pkg::t_in_req                  o_data,
    output asb_pkg::t_pix_ctl                 o_ctl,
    output logic [$clog2(MAX_DEST_DIM)-1:0]   o_px,
    output logic [$clog2(MAX_DEST_DIM)-1:0]   o_py
);

    localparam int SDW   = $clog2(MAX_SPRITE_DIM + 1);
    localparam int CW    = $clog2(MAX_SPRITE_DIM);
    localparam int AW    = $clog2(MAX_DEST_DIM);
    localparam int POS_W = asb_pkg::POS_W;

    logic [CW-1:0]    r_col, n_col;
    logic [CW-1:0]    r_row, n_row;
    logic             r_valid;
    asb_pkg::t_in_req r_data;
    asb_pkg::t_pix_ctl r_ctl, n_ctl;
    logic [AW-1:0]    r_px, n_px;
    logic [AW-1:0]    r_py, n_py;

    logic [SDW-1:0]   w_sw, w_sh;
    logic [POS_W-1:0] w_ax, w_ay, w_x, w_y;
    logic             w_vis, w_end_col, w_end_row, w_accept;

    always_comb begin
        if (i_cfg.sprite_width == '0) begin
            w_sw = SDW'(1);
        end else if (POS_W'(i_cfg.sprite_width) > POS_W'(MAX_SPRITE_DIM)) begin
            w_sw = SDW'(MAX_SPRITE_DIM);
        end else begin
            w_sw = SDW'(i_cfg.sprite_width);
        end
        if (i_cfg.sprite_height == '0) begin
            w_sh = SDW'(1);
        end else if (POS_W'(i_cfg.sprite_height) > POS_W'(MAX_SPRITE_DIM)) begin
            w_sh = SDW'(MAX_SPRITE_DIM);
        end else begin
            w_sh = SDW'(i_cfg.sprite_height);
        end
    end

    always_comb begin
        w_ax = {{(POS_W-14){i_cfg.pos_x[13]}}, i_cfg.pos_x};
        w_ay = {{(POS_W-14){i_cfg.pos_y[13]}}, i_cfg.pos_y};
        if (i_cfg.center_anchor) begin
            w_ax = w_ax - POS_W'(w_sw >> 1);
            w_ay = w_ay - POS_W'(w_sh >> 1);
        end
        w_x = w_ax + POS_W'(r_col);
        w_y = w_ay + POS_W'(r_row);
        // sign bit clear means the coordinate is on or right/below the origin
        w_vis = !w_x[POS_W-1] && !w_y[POS_W-1]
              && (w_x < POS_W'(i_dw)) && (w_y < POS_W'(i_dh));
        w_end_col = (POS_W'(r_col) + POS_W'(1)) >= POS_W'(w_sw);
        w_end_row = (POS_W'(r_row) + POS_W'(1)) >= POS_W'(w_sh);

        n_ctl.write_enable = w_vis && (i_in_data.src_alpha != asb_pkg::ALPHA_CLEAR);
        n_ctl.last_pixel   = w_end_col && w_end_row;
        n_px = n_ctl.write_enable ? w_x[AW-1:0] : '0;
        n_py = n_ctl.write_enable ? w_y[AW-1:0] : '0;

        w_accept = i_in_valid && i_ready;
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            priority if (n_ctl.last_pixel) begin
                n_col = '0;
                n_row = '0;
            end else if (w_end_col) begin
                n_col = '0;
                n_row = r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_ready) begin
                r_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data <= i_in_data;
            r_ctl  <= n_ctl;
            r_px   <= n_px;
            r_py   <= n_py;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_ctl   = r_ctl;
    assign o_px    = r_px;
    assign o_py    = r_py;

endmodule

@@ hdl/asb_out.sv @@
module asb_out #(
    parameter int MAX_DEST_DIM = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [$clog2(MAX_DEST_DIM+1)-1:0] i_dw,
    input  logic                              i_valid,
    input  logic                              i_ready,
    input  asb_pkg::t_in_req                  i_data,
    input  asb_pkg::t_pix_ctl                 i_ctl,
    input  logic [$clog2(MAX_DEST_DIM)-1:0]   i_px,
    input  logic [$clog2(MAX_DEST_DIM)-1:0]   i_py,
    output logic                              o_valid,
    output asb_pkg::t_out_req                 o_data
);

    localparam int DDW = $clog2(MAX_DEST_DIM + 1);
    localparam int AW  = $clog2(MAX_DEST_DIM);
    localparam int MW  = AW + DDW;

    logic              r_valid;
    asb_pkg::t_out_req r_data, n_data;
    logic [MW-1:0]     w_prod;
    logic [MW:0]       w_addr;

    always_comb begin
        w_prod = MW'(i_py) * MW'(i_dw);
        w_addr = (MW+1)'(w_prod) + (MW+1)'(i_px);

        n_data = '0;
        n_data.last_pixel = i_ctl.last_pixel;
        if (i_ctl.write_enable) begin
            n_data.write_enable  = 1'b1;
            n_data.pixel_address = 24'(w_addr);
            if (i_data.src_alpha == asb_pkg::ALPHA_OPAQUE) begin
                n_data.out_c0 = i_data.src_c0;
                n_data.out_c1 = i_data.src_c1;
                n_data.out_c2 = i_data.src_c2;
            end else begin
                n_data.out_c0 = asb_pkg::blend(i_data.src_c0, i_data.dst_c0, i_data.src_alpha);
                n_data.out_c1 = asb_pkg::blend(i_data.src_c1, i_data.dst_c1, i_data.src_alpha);
                n_data.out_c2 = asb_pkg::blend(i_data.src_c2, i_data.dst_c2, i_data.src_alpha);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ hdl/alpha_sprite_blitter_top.sv @@
// Alpha-blended sprite blitter.
// Feed the sprite pixels in raster order on the input channel (i_in_valid,
// o_in_stall, i_in_data): sprite colour, alpha and the destination colour
// under that pixel. One request comes back on the output channel
// (o_out_valid, i_out_stall, o_out_data) for every request taken: write
// enable, destination address and colour, with last_pixel on the final
// pixel of the sprite, after which the counters restart for the next blit.
// The path holds one register after the position/clip stage and
// one output register after the address multiply and colour blend.
// Throughput is one pixel per cycle; the column/row counters step on every
// accepted request. A stall on the output holds the output register, and
// the input stage keeps taking requests until its own register is full.
// Settings go in through i_cfg_we/i_cfg_index/i_cfg_data; write them only
// while no pixel is in flight. Reset empties both stages, zeroes the
// counters and loads destination 640x480, sprite 1x1, position 0,0 with
// centered anchoring.
module alpha_sprite_blitter_top #(
    parameter int MAX_DEST_DIM   = 4096,
    parameter int MAX_SPRITE_DIM = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [asb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [asb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  asb_pkg::t_in_req                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output asb_pkg::t_out_req                   o_out_data
);

    localparam int DDW   = $clog2(MAX_DEST_DIM + 1);
    localparam int AW    = $clog2(MAX_DEST_DIM);
    localparam int POS_W = asb_pkg::POS_W;

    asb_pkg::t_cfg     r_cfg;
    logic [DDW-1:0]    w_dw, w_dh;
    logic              w_s1_ready, w_s2_ready;
    logic              w_s1_valid;
    asb_pkg::t_in_req  w_s1_data;
    asb_pkg::t_pix_ctl w_s1_ctl;
    logic [AW-1:0]     w_s1_px, w_s1_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_width    <= 13'd640;
            r_cfg.dest_height   <= 13'd480;
            r_cfg.sprite_width  <= 11'd1;
            r_cfg.sprite_height <= 11'd1;
            r_cfg.pos_x         <= '0;
            r_cfg.pos_y         <= '0;
            r_cfg.center_anchor <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                asb_pkg::REG_DEST_WIDTH:    r_cfg.dest_width    <= i_cfg_data[12:0];
                asb_pkg::REG_DEST_HEIGHT:   r_cfg.dest_height   <= i_cfg_data[12:0];
                asb_pkg::REG_SPRITE_WIDTH:  r_cfg.sprite_width  <= i_cfg_data[10:0];
                asb_pkg::REG_SPRITE_HEIGHT: r_cfg.sprite_height <= i_cfg_data[10:0];
                asb_pkg::REG_POS_X:         r_cfg.pos_x         <= i_cfg_data[13:0];
                asb_pkg::REG_POS_Y:         r_cfg.pos_y         <= i_cfg_data[13:0];
                asb_pkg::REG_CENTER_ANCHOR: r_cfg.center_anchor <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp the destination size to what the address path supports
    always_comb begin
        w_dw = (POS_W'(r_cfg.dest_width) > POS_W'(MAX_DEST_DIM))
             ? DDW'(MAX_DEST_DIM) : DDW'(r_cfg.dest_width);
        w_dh = (POS_W'(r_cfg.dest_height) > POS_W'(MAX_DEST_DIM))
             ? DDW'(MAX_DEST_DIM) : DDW'(r_cfg.dest_height);
    end

    assign w_s2_ready = !o_out_valid || !i_out_stall;
    assign w_s1_ready = !w_s1_valid || w_s2_ready;
    assign o_in_stall = !w_s1_ready;

    asb_pos #(
        .MAX_DEST_DIM   (MAX_DEST_DIM),
        .MAX_SPRITE_DIM (MAX_SPRITE_DIM)
    ) u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_dw       (w_dw),
        .i_dh       (w_dh),
        .i_in_valid (i_in_valid),
        .i_ready    (w_s1_ready),
        .i_in_data  (i_in_data),
        .o_valid    (w_s1_valid),
        .o_data     (w_s1_data),
        .o_ctl      (w_s1_ctl),
        .o_px       (w_s1_px),
        .o_py       (w_s1_py)
    );

    asb_out #(
        .MAX_DEST_DIM (MAX_DEST_DIM)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dw    (w_dw),
        .i_valid (w_s1_valid),
        .i_ready (w_s2_ready),
        .i_data  (w_s1_data),
        .i_ctl   (w_s1_ctl),
        .i_px    (w_s1_px),
        .i_py    (w_s1_py),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

@@ sim/tb_alpha_sprite_blitter_top.sv @@
module tb_alpha_sprite_blitter_top;

    localparam logic [asb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int TOTAL_PIXELS = 1950;
    localparam int LONG_HOLD    = 64;
    localparam int QUIET_LIMIT  = 4000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    class blit_scoreboard;
        localparam int SPRITE_DIM_MAX = 1024;
        localparam int DEST_DIM_MAX   = 4096;

        int dest_w, dest_h, spr_w, spr_h, org_x, org_y;
        bit centered;
        int col, row;
        asb_pkg::t_out_req expected_writes[$];
        int errors;

        function new();
            dest_w = 640;
            dest_h = 480;
            spr_w = 1;
            spr_h = 1;
            org_x = 0;
            org_y = 0;
            centered = 1'b1;
            col = 0;
            row = 0;
            errors = 0;
        endfunction

        function int clamp(int v, int lo, int hi);
            return (v < lo) ? lo : (v > hi) ? hi : v;
        endfunction

        task report(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        function void write_reg(logic [asb_pkg::CFG_IDX_W-1:0] idx,
                                logic [asb_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                asb_pkg::REG_DEST_WIDTH:    dest_w = val[12:0];
                asb_pkg::REG_DEST_HEIGHT:   dest_h = val[12:0];
                asb_pkg::REG_SPRITE_WIDTH:  spr_w = val[10:0];
                asb_pkg::REG_SPRITE_HEIGHT: spr_h = val[10:0];
                asb_pkg::REG_POS_X:         org_x = $signed(val);
                asb_pkg::REG_POS_Y:         org_y = $signed(val);
                asb_pkg::REG_CENTER_ANCHOR: centered = val[0];
                default: ;
            endcase
        endfunction

        // dst plus the floored scaled difference, wrapped to a byte
        function logic [7:0] mix(logic [7:0] s, logic [7:0] d, logic [7:0] a);
            int delta, sum;
            delta = (int'(a) * (int'(s) - int'(d))) >>> 8;
            sum = int'(d) + delta;
            return sum[7:0];
        endfunction

        function int pixels_to_end();
            int sw, sh, tail;
            sw = clamp(spr_w, 1, SPRITE_DIM_MAX);
            sh = clamp(spr_h, 1, SPRITE_DIM_MAX);
            tail = (col + 1 >= sw) ? 1 : sw - col;
            return (row + 1 >= sh) ? tail : tail + (sh - row - 1) * sw;
        endfunction

        function void note_pixel(asb_pkg::t_in_req p);
            int sw, sh, dw, dh, px, py, addr;
            bit end_col, last;
            asb_pkg::t_out_req w;
            sw = clamp(spr_w, 1, SPRITE_DIM_MAX);
            sh = clamp(spr_h, 1, SPRITE_DIM_MAX);
            dw = clamp(dest_w, 0, DEST_DIM_MAX);
            dh = clamp(dest_h, 0, DEST_DIM_MAX);
            px = org_x - (centered ? sw / 2 : 0) + col;
            py = org_y - (centered ? sh / 2 : 0) + row;
            w = '0;
            if (px >= 0 && py >= 0 && px < dw && py < dh
                && p.src_alpha != asb_pkg::ALPHA_CLEAR) begin
                addr = py * dw + px;
                w.write_enable = 1'b1;
                w.pixel_address = addr[23:0];
                if (p.src_alpha == asb_pkg::ALPHA_OPAQUE) begin
                    w.out_c0 = p.src_c0;
                    w.out_c1 = p.src_c1;
                    w.out_c2 = p.src_c2;
                end else begin
                    w.out_c0 = mix(p.src_c0, p.dst_c0, p.src_alpha);
                    w.out_c1 = mix(p.src_c1, p.dst_c1, p.src_alpha);
                    w.out_c2 = mix(p.src_c2, p.dst_c2, p.src_alpha);
                end
            end
            end_col = (col + 1 >= sw);
            last = end_col && (row + 1 >= sh);
            w.last_pixel = last;
            expected_writes.insert(expected_writes.size(), w);
            // a counter past a shrunk size wraps like one at the end
            if (last) begin
                col = 0;
                row = 0;
            end else if (end_col) begin
                col = 0;
                row++;
            end else begin
                col++;
            end
        endfunction

        task check_write(asb_pkg::t_out_req got);
            asb_pkg::t_out_req want;
            if (expected_writes.size() == 0) begin
                report($sformatf("unexpected write %h", got));
                return;
            end
            want = expected_writes.pop_front();
            if (got.write_enable !== want.write_enable)
                report($sformatf("write_enable %b want %b", got.write_enable, want.write_enable));
            if (got.pixel_address !== want.pixel_address)
                report($sformatf("pixel_address %h want %h", got.pixel_address,
                                 want.pixel_address));
            if (got.out_c0 !== want.out_c0)
                report($sformatf("out_c0 %h want %h", got.out_c0, want.out_c0));
            if (got.out_c1 !== want.out_c1)
                report($sformatf("out_c1 %h want %h", got.out_c1, want.out_c1));
            if (got.out_c2 !== want.out_c2)
                report($sformatf("out_c2 %h want %h", got.out_c2, want.out_c2));
            if (got.last_pixel !== want.last_pixel)
                report($sformatf("last_pixel %b want %b", got.last_pixel, want.last_pixel));
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [asb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [asb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    asb_pkg::t_in_req               in_data = '0;
    logic                           out_stall = 1'b0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    asb_pkg::t_out_req              o_out_data;

    blit_scoreboard sb;
    logic [asb_pkg::CFG_DATA_W-1:0] setup_val [0:6];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_reqs = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    wire take_in  = in_valid && !o_in_stall;
    wire take_out = o_out_valid && !out_stall;

    alpha_sprite_blitter_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (take_in) sb.note_pixel(in_data);
            if (take_out) sb.check_write(o_out_data);
        end
    end

    // long hold-offs are counted here; otherwise stall at the current rate
    always @(posedge clk) begin
        if (hold_reqs != hold_served) begin
            hold_served <= hold_reqs;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && (take_in || take_out)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pixel(input asb_pkg::t_in_req p);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= p;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
    endtask

    // stop offering and wait until every expected write has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_writes.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic put_reg(input logic [asb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [asb_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic write_setup(input logic [6:0] sel, input bit poke_unused);
        for (int i = 0; i < 7; i++) begin
            if (sel[i]) put_reg(asb_pkg::CFG_IDX_W'(i), setup_val[i]);
        end
        if (poke_unused) put_reg(REG_UNUSED, asb_pkg::CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic set_idle(input t_idle_mode m);
        send_idle_pct = (m == IDLE_SEND) ? 54 : (m == IDLE_BOTH) ? 37 : 0;
        recv_stall_pct <= (m == IDLE_RECV) ? 54 : (m == IDLE_BOTH) ? 37 : 0;
    endtask

    function automatic asb_pkg::t_in_req mk_pixel(input logic [7:0] s0, input logic [7:0] s1,
                                                  input logic [7:0] s2, input logic [7:0] a,
                                                  input logic [7:0] d0, input logic [7:0] d1,
                                                  input logic [7:0] d2);
        asb_pkg::t_in_req p;
        p.src_c0 = s0;
        p.src_c1 = s1;
        p.src_c2 = s2;
        p.src_alpha = a;
        p.dst_c0 = d0;
        p.dst_c1 = d1;
        p.dst_c2 = d2;
        return p;
    endfunction

    function automatic asb_pkg::t_in_req rand_pixel();
        asb_pkg::t_in_req p;
        p = 56'({$urandom, $urandom});
        case ($urandom_range(4))
            0: p.src_alpha = asb_pkg::ALPHA_CLEAR;
            1: p.src_alpha = asb_pkg::ALPHA_OPAQUE;
            2: p.dst_c1 = p.src_c1;
            default: ;
        endcase
        return p;
    endfunction

    function automatic int pick_dest_dim();
        case ($urandom_range(9))
            0: return 0;
            1: return $urandom_range(4097, 16383);
            2: return 4096;
            3: return $urandom_range(1, 4096);
            default: return $urandom_range(1, 24);
        endcase
    endfunction

    function automatic int pick_sprite_dim();
        case ($urandom_range(7))
            0: return 0;
            1: return $urandom_range(1, 16383);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // aim around the clip edges in two of the five cases
    function automatic int pick_pos(input int extent);
        if (extent > 4096) extent = 4096;
        case ($urandom_range(4))
            0: return $urandom_range(16383);
            1: return extent - 8 + int'($urandom_range(16));
            2: return int'($urandom_range(16)) - 8;
            default: return $urandom_range(extent);
        endcase
    endfunction

    task automatic pick_setup();
        int dw, dh;
        dw = pick_dest_dim();
        dh = pick_dest_dim();
        setup_val[asb_pkg::REG_DEST_WIDTH] = asb_pkg::CFG_DATA_W'(dw);
        setup_val[asb_pkg::REG_DEST_HEIGHT] = asb_pkg::CFG_DATA_W'(dh);
        setup_val[asb_pkg::REG_SPRITE_WIDTH] = asb_pkg::CFG_DATA_W'(pick_sprite_dim());
        setup_val[asb_pkg::REG_SPRITE_HEIGHT] = asb_pkg::CFG_DATA_W'(pick_sprite_dim());
        setup_val[asb_pkg::REG_POS_X] = asb_pkg::CFG_DATA_W'(pick_pos(dw % 8192));
        setup_val[asb_pkg::REG_POS_Y] = asb_pkg::CFG_DATA_W'(pick_pos(dh % 8192));
        setup_val[asb_pkg::REG_CENTER_ANCHOR] = asb_pkg::CFG_DATA_W'($urandom_range(3));
    endtask

    initial begin
        int n, phase, items_sent;
        sb = new();
        items_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one pixel sprite centered on the origin
        send_pixel(mk_pixel(8'h12, 8'h34, 8'h56, asb_pkg::ALPHA_OPAQUE, 8'h00, 8'h00, 8'h00));
        send_pixel(mk_pixel(8'hff, 8'hff, 8'hff, asb_pkg::ALPHA_CLEAR, 8'h00, 8'h00, 8'h00));
        send_pixel(mk_pixel(8'h00, 8'hff, 8'h80, 8'h80, 8'hff, 8'h00, 8'h80));
        send_pixel(mk_pixel(8'hff, 8'h00, 8'h01, 8'h01, 8'h00, 8'hff, 8'hfe));
        items_sent += 4;
        drain();

        // clipped on the left and bottom; hold the output so the input backs up
        setup_val[asb_pkg::REG_DEST_WIDTH] = 4;
        setup_val[asb_pkg::REG_DEST_HEIGHT] = 3;
        setup_val[asb_pkg::REG_SPRITE_WIDTH] = 3;
        setup_val[asb_pkg::REG_SPRITE_HEIGHT] = 2;
        setup_val[asb_pkg::REG_POS_X] = -1;
        setup_val[asb_pkg::REG_POS_Y] = 2;
        setup_val[asb_pkg::REG_CENTER_ANCHOR] = 0;
        write_setup(7'h7f, 1'b0);
        hold_reqs <= hold_reqs + 1;
        repeat (12) send_pixel(rand_pixel());
        items_sent += 12;
        drain();

        // oversized destination and sprite, top address, then shrink mid-blit
        setup_val[asb_pkg::REG_DEST_WIDTH] = 8191;
        setup_val[asb_pkg::REG_DEST_HEIGHT] = 8191;
        setup_val[asb_pkg::REG_SPRITE_WIDTH] = 0;
        setup_val[asb_pkg::REG_SPRITE_HEIGHT] = 2047;
        setup_val[asb_pkg::REG_POS_X] = 4095;
        setup_val[asb_pkg::REG_POS_Y] = 4607;
        setup_val[asb_pkg::REG_CENTER_ANCHOR] = 1;
        write_setup(7'h7f, 1'b0);
        send_pixel(mk_pixel(8'hff, 8'hff, 8'hff, asb_pkg::ALPHA_OPAQUE, 8'h00, 8'h00, 8'h00));
        send_pixel(rand_pixel());
        drain();
        setup_val[asb_pkg::REG_SPRITE_HEIGHT] = 1;
        write_setup(7'(1) << asb_pkg::REG_SPRITE_HEIGHT, 1'b0);
        send_pixel(rand_pixel());
        items_sent += 3;
        drain();

        // zero-width destination, plus a write to an unknown register
        setup_val[asb_pkg::REG_DEST_WIDTH] = 0;
        setup_val[asb_pkg::REG_DEST_HEIGHT] = 5;
        setup_val[asb_pkg::REG_SPRITE_WIDTH] = 2;
        setup_val[asb_pkg::REG_POS_X] = 0;
        setup_val[asb_pkg::REG_POS_Y] = 0;
        setup_val[asb_pkg::REG_CENTER_ANCHOR] = 0;
        write_setup(7'h7f, 1'b1);
        repeat (2) send_pixel(mk_pixel(8'h80, 8'h80, 8'h80, asb_pkg::ALPHA_OPAQUE,
                                       8'h00, 8'h00, 8'h00));
        items_sent += 2;
        drain();

        // position extremes, both off the surface
        setup_val[asb_pkg::REG_DEST_WIDTH] = 16;
        setup_val[asb_pkg::REG_DEST_HEIGHT] = 16;
        setup_val[asb_pkg::REG_SPRITE_WIDTH] = 1;
        setup_val[asb_pkg::REG_POS_X] = -8192;
        setup_val[asb_pkg::REG_POS_Y] = 8191;
        write_setup(7'h7f, 1'b0);
        send_pixel(rand_pixel());
        setup_val[asb_pkg::REG_POS_X] = 8191;
        setup_val[asb_pkg::REG_POS_Y] = -8192;
        drain();
        write_setup((7'(1) << asb_pkg::REG_POS_X) | (7'(1) << asb_pkg::REG_POS_Y), 1'b0);
        send_pixel(rand_pixel());
        items_sent += 2;

        phase = 0;
        while (items_sent < TOTAL_PIXELS) begin
            drain();
            set_idle(t_idle_mode'((phase / 8) % 4));
            pick_setup();
            write_setup(($urandom_range(9) < 7) ? 7'h7f : 7'($urandom), $urandom_range(4) == 0);
            n = sb.pixels_to_end();
            // leave some blits unfinished so later size changes hit live counters
            if (n > 48 || $urandom_range(3) == 0) n = $urandom_range(1, (n > 48) ? 48 : n);
            if (phase % 37 == 5) begin
                send_idle_pct = 0;
                hold_reqs <= hold_reqs + 1;
                if (n < 16) n = 16;
            end
            repeat (n) send_pixel(rand_pixel());
            items_sent += n;
            phase++;
        end
        drain();

        if (sb.expected_writes.size() != 0) sb.report("writes still pending at the end");
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
